// ----- design/ffca_pkg.sv -----
package ffca_pkg;

  localparam int OP_W   = 2;
  localparam int ARG_W  = 16;
  localparam int STAT_W = 2;
  localparam int HOUT_W = 16;
  localparam int CFG_W  = 8;

  localparam logic [CFG_W-1:0] CFG_ARENA_RESET = 8'd128;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEFRAG = 2'd2;

  localparam logic [STAT_W-1:0] STAT_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_ROOM   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ERASE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_FILL
  } state_t;

endpackage

// ----- design/first_fit_cell_allocator.sv -----
// Channel   Ports                                       Handshake
// ------    ------------------------------------------  ---------------------------------
// input     in_operation, in_size_or_handle             start high while busy is low
// result    out_status, out_handle                      out_valid strobe, one cycle
// config    cfg_arena_size                              cfg_valid and cfg_ready
//
// Erase and defragment walk the store through its one read port, a cell per cycle, over the
// effective arena size; a defragment then clears the freed cells at the top, one per cycle.
// An alloc walks until the cell that completes its run (the whole walk when none does), tags
// one cell per cycle and then reports. Refused and zero-cell allocs and erases of handle zero
// answer without raising busy. Reset starts a clearing pass over all CELLS cells under busy.
// The receiver cannot stall.
module first_fit_cell_allocator #(
  parameter int CELLS       = 128,
  parameter int HANDLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ffca_pkg::OP_W-1:0]       in_operation,
  input  logic [ffca_pkg::ARG_W-1:0]      in_size_or_handle,
  output logic                            out_valid,
  output logic [ffca_pkg::STAT_W-1:0]     out_status,
  output logic [ffca_pkg::HOUT_W-1:0]     out_handle,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffca_pkg::CFG_W-1:0]      cfg_arena_size
);

  import ffca_pkg::*;

  // Index width holds every value from 0 to CELLS; address width just indexes the store.
  localparam int IW = $clog2(CELLS + 1);
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CELLS - 1);
  localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

  // Cell store: one write port and one registered read port.
  logic [HANDLE_BITS-1:0] mem [CELLS];
  logic [HANDLE_BITS-1:0] rdata_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]        op_r, op_nxt;
  logic [ARG_W-1:0]       arg_r, arg_nxt;
  logic [IW-1:0]          size_r, size_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   dv_r, dv_nxt;
  logic [IW-1:0]          didx_r, didx_nxt;
  logic [IW-1:0]          run_r, run_nxt;
  logic [IW-1:0]          want_r, want_nxt;
  logic [IW-1:0]          k_r, k_nxt;
  logic [IW-1:0]          wr_r, wr_nxt;
  logic [IW-1:0]          end_r, end_nxt;
  logic                   present_r, present_nxt;
  logic [HANDLE_BITS-1:0] next_handle_r, next_handle_nxt;
  logic [CFG_W-1:0]       arena_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [HOUT_W-1:0]      out_handle_r, out_handle_nxt;

  logic [IW-1:0]          size_w;
  logic                   handle_full;
  logic                   want_zero;
  logic                   want_too_big;
  logic                   alloc_quick;
  logic                   is_free;
  logic [IW-1:0]          run_inc;
  logic                   hit;
  logic                   scan_done;
  logic                   owner_match;
  logic                   accept;

  // The effective arena is the configured size saturated to the store depth.
  assign size_w       = (32'(arena_r) > CELLS) ? IW'(CELLS) : IW'(arena_r);
  assign handle_full  = (next_handle_r == HANDLE_MAX);
  assign want_zero    = (in_size_or_handle == '0);
  assign want_too_big = (32'(in_size_or_handle) > 32'(size_w));
  // An alloc that needs no scan: counter exhausted, zero cells, or more than the arena.
  assign alloc_quick  = handle_full || want_zero || want_too_big;
  assign accept       = start && (state_r == ST_IDLE);

  // Scan pipeline: rdata_r holds the owner of cell didx_r whenever dv_r is set.
  assign is_free     = (rdata_r == '0);
  assign run_inc     = run_r + 1'b1;
  assign hit         = dv_r && (op_r == OP_ALLOC) && is_free && (run_inc == want_r);
  assign scan_done   = !dv_r && (idx_r >= size_r);
  assign owner_match = (32'(rdata_r) == 32'(arg_r));

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_handle = out_handle_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_ALLOC) begin
            if (!alloc_quick) begin
              state_nxt = ST_SCAN;
            end
          end else if (in_operation == OP_ERASE) begin
            if (in_size_or_handle != '0) begin
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_FILL;
        end else if (scan_done) begin
          state_nxt = (op_r == OP_DEFRAG) ? ST_FILL : ST_IDLE;
        end
      end
      ST_FILL: begin
        if (wr_r >= end_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store writes and results.
  always_comb begin
    op_nxt          = op_r;
    arg_nxt         = arg_r;
    size_nxt        = size_r;
    idx_nxt         = idx_r;
    dv_nxt          = 1'b0;
    didx_nxt        = didx_r;
    run_nxt         = run_r;
    want_nxt        = want_r;
    k_nxt           = k_r;
    wr_nxt          = wr_r;
    end_nxt         = end_r;
    present_nxt     = present_r;
    next_handle_nxt = next_handle_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_handle_nxt  = out_handle_r;
    mem_we          = 1'b0;
    mem_waddr       = wr_r[AW-1:0];
    mem_wdata       = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_ALLOC) begin
            op_nxt = OP_ALLOC;
          end else if (in_operation == OP_ERASE) begin
            op_nxt = OP_ERASE;
          end else begin
            op_nxt = OP_DEFRAG;
          end
          arg_nxt     = in_size_or_handle;
          size_nxt    = size_w;
          want_nxt    = IW'(in_size_or_handle);
          idx_nxt     = '0;
          run_nxt     = '0;
          k_nxt       = '0;
          present_nxt = 1'b0;
          if (in_operation == OP_ALLOC) begin
            if (handle_full || (!want_zero && want_too_big)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NO_ROOM;
              out_handle_nxt = '0;
            end else if (want_zero) begin
              // A zero-length alloc succeeds without tagging a cell.
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STAT_ALLOCATED;
              out_handle_nxt  = HOUT_W'(next_handle_r);
              next_handle_nxt = next_handle_r + 1'b1;
            end
          end else if (in_operation == OP_ERASE) begin
            if (want_zero) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_BAD_ERASE;
              out_handle_nxt = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (idx_r < size_r) begin
          idx_nxt  = idx_r + 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = idx_r;
        end
        case (op_r)
          OP_ALLOC: begin
            if (dv_r) begin
              run_nxt = is_free ? run_inc : '0;
            end
            if (hit) begin
              wr_nxt  = didx_r + 1'b1 - want_r;
              end_nxt = didx_r + 1'b1;
            end else if (scan_done) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_NO_ROOM;
              out_handle_nxt = '0;
            end
          end
          OP_ERASE: begin
            if (dv_r && owner_match) begin
              mem_we      = 1'b1;
              mem_waddr   = didx_r[AW-1:0];
              present_nxt = 1'b1;
            end
            if (scan_done && !present_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_BAD_ERASE;
              out_handle_nxt = '0;
            end
          end
          default: begin
            // Compaction: a used cell moves down to the write pointer.
            if (dv_r && !is_free) begin
              mem_we    = 1'b1;
              mem_waddr = k_r[AW-1:0];
              mem_wdata = rdata_r;
              k_nxt     = k_r + 1'b1;
            end
            if (scan_done) begin
              wr_nxt  = k_r;
              end_nxt = size_r;
            end
          end
        endcase
      end
      ST_FILL: begin
        if (wr_r < end_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[AW-1:0];
          mem_wdata = (op_r == OP_ALLOC) ? next_handle_r : '0;
          wr_nxt    = wr_r + 1'b1;
        end else if (op_r == OP_ALLOC) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = STAT_ALLOCATED;
          out_handle_nxt  = HOUT_W'(next_handle_r);
          next_handle_nxt = next_handle_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      idx_r         <= '0;
      dv_r          <= 1'b0;
      next_handle_r <= HANDLE_BITS'(1);
      arena_r       <= CFG_ARENA_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      dv_r          <= dv_nxt;
      next_handle_r <= next_handle_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        arena_r <= cfg_arena_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    arg_r        <= arg_nxt;
    size_r       <= size_nxt;
    didx_r       <= didx_nxt;
    run_r        <= run_nxt;
    want_r       <= want_nxt;
    k_r          <= k_nxt;
    wr_r         <= wr_nxt;
    end_r        <= end_nxt;
    present_r    <= present_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
  end

endmodule
